// ----- rtl/core/rbs_pkg.sv -----
`default_nettype none

package rbs_pkg;

    localparam int TIMEOUT_W  = 8;
    localparam int RATE_W     = 16;
    localparam int LIMIT_W    = 8;
    localparam int TICKS_W    = 24;
    localparam int COUNT_W    = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 8'd3;
    localparam logic [RATE_W-1:0]    RATE_RST    = 16'd100;
    localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 8'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_PENDING   = 2'd1,
        MODE_EMERGENCY = 2'd2
    } mode_t;

    typedef struct packed {
        logic [COUNT_W-1:0] push_count;
        mode_t              mode;
        logic               cancelled;
        logic               emergency_restart;
        logic               normal_restart;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- rtl/core/rbs_core.sv -----
`default_nettype none

module rbs_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rbs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            item_accept,
    input  wire logic                            item_op,
    input  wire logic                            item_released,
    output rbs_pkg::result_t                     item_result
);
    import rbs_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [TICKS_W-1:0]   deadline_reg, deadline_next;

    mode_t              mode_reg, mode_next;
    logic [TICKS_W-1:0] elapsed_reg, elapsed_next;
    logic               armed_reg, armed_next;
    logic [COUNT_W-1:0] pushes_reg, pushes_next;
    logic [TICKS_W-1:0] elapsed_inc;
    logic               normal, emerg, canc;

    // recompute the deadline with the new value so it is ready at once
    always_comb begin
        deadline_next = deadline_reg;
        if (cfg_index == CFG_TIMEOUT) begin
            deadline_next = TICKS_W'(cfg_data[TIMEOUT_W-1:0]) * TICKS_W'(rate_reg);
        end else if (cfg_index == CFG_RATE) begin
            deadline_next = TICKS_W'(timeout_reg) * TICKS_W'(cfg_data[RATE_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= TIMEOUT_RST;
            rate_reg     <= RATE_RST;
            limit_reg    <= LIMIT_RST;
            deadline_reg <= TICKS_W'(TIMEOUT_RST) * TICKS_W'(RATE_RST);
        end else if (cfg_wr_en) begin
            deadline_reg <= deadline_next;
            unique case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                CFG_RATE:    rate_reg    <= cfg_data[RATE_W-1:0];
                CFG_LIMIT:   limit_reg   <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate the tick count at its full range
    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + TICKS_W'(1) : elapsed_reg;

    always_comb begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        armed_next   = armed_reg;
        pushes_next  = pushes_reg;
        normal       = 1'b0;
        emerg        = 1'b0;
        canc         = 1'b0;
        if (item_op == OP_TICK) begin
            if (armed_reg) begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc >= deadline_reg) begin
                    normal     = 1'b1;
                    armed_next = 1'b0;
                end
            end
        end else if (!item_released) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    mode_next    = MODE_PENDING;
                    elapsed_next = '0;
                    armed_next   = 1'b1;
                end
                MODE_PENDING: begin
                    armed_next = 1'b0;
                    if (armed_reg && elapsed_reg < deadline_reg) begin
                        mode_next = MODE_IDLE;
                        canc      = 1'b1;
                    end else begin
                        mode_next   = MODE_EMERGENCY;
                        pushes_next = '0;
                    end
                end
                MODE_EMERGENCY: begin
                    if (pushes_reg < limit_reg) begin
                        pushes_next = pushes_reg + COUNT_W'(1);
                    end
                    emerg = (pushes_next >= limit_reg);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            elapsed_reg <= '0;
            armed_reg   <= 1'b0;
            pushes_reg  <= '0;
        end else if (item_accept) begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            armed_reg   <= armed_next;
            pushes_reg  <= pushes_next;
        end
    end

    assign item_result.normal_restart    = normal;
    assign item_result.emergency_restart = emerg;
    assign item_result.cancelled         = canc;
    assign item_result.mode              = mode_next;
    assign item_result.push_count        = pushes_next;

`ifndef NO_ASSERTIONS
    a_armed_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        armed_reg |-> mode_reg == MODE_PENDING)
        else $error("countdown running outside pending mode");
    a_normal_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        item_accept && normal |=> !armed_reg)
        else $error("countdown still running after normal restart");
    a_cancel_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        item_accept && canc |=> mode_reg == MODE_IDLE && !armed_reg)
        else $error("cancel did not return to idle");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/rbs_out_skid.sv -----
`default_nettype none

module rbs_out_skid (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rbs_pkg::result_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output rbs_pkg::result_t      out_data
);
    import rbs_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_data_reg;
    result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            // output stalled: hold the transfer in the skid stage
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !main_valid_reg) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && in_ready) begin
            skid_data_reg <= in_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage filled while output stage empty");
    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready && main_valid_reg && !out_ready |=> skid_valid_reg)
        else $error("transfer lost during output stall");
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && out_ready |=> main_valid_reg && !skid_valid_reg)
        else $error("skid stage did not drain");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/reset_button_supervisor.sv -----
// Reset push-button supervisor.
// Input stream: one transfer per tick or button event. s_tuser carries the
// operation (0 tick, 1 button), s_tdata[0] the raw switch bit (1 released).
// Result stream: one result per input transfer on m_tdata. While m_tready is
// high, each is valid the cycle after its input is taken, one item per cycle;
// the state update and the result are formed in a single pass from the
// current state, and the countdown deadline is a registered product of the
// two timing registers, so the tick path holds only an add and a compare.
// Configuration: cfg_wr_en, cfg_index, cfg_data write one register per
// cycle (0 timeout seconds, 1 ticks per second, 2 emergency push limit);
// write only while no results are outstanding.
// Reset (aresetn low, synchronous) returns to idle with the countdown
// stopped, the push count cleared and the registers at 3, 100 and 10.
// When the receiver stalls, the output register holds its result and a
// skid stage takes one more transfer; s_tready then falls until it drains.
`default_nettype none

module reset_button_supervisor (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rbs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // [0] switch_released
    input  wire logic                            s_tuser,  // [0] operation
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] normal_restart, [1] emergency_restart, [2] cancelled, [4:3] mode,
    // [12:5] push_count
    output logic [rbs_pkg::TDATA_W-1:0]          m_tdata
);
    import rbs_pkg::*;

    logic    accept;
    result_t core_result;
    result_t out_result;

    assign accept = s_tvalid && s_tready;

    rbs_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_accept   (accept),
        .item_op       (s_tuser),
        .item_released (s_tdata[0]),
        .item_result   (core_result)
    );

    rbs_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = TDATA_W'(out_result);

endmodule

`default_nettype wire
